/* sv/smh_pkg.sv */
// ----------------------------------------------------------------------------
// smh_pkg
// Shared types, register map and helpers for the servo mixer with hold PID.
// ----------------------------------------------------------------------------
package smh_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_NEUTRAL   = 3'd0;
  localparam logic [2:0] REG_TRIM      = 3'd1;
  localparam logic [2:0] REG_GAIN      = 3'd2;
  localparam logic [2:0] REG_LOW_LIM   = 3'd3;
  localparam logic [2:0] REG_HIGH_LIM  = 3'd4;
  localparam logic [2:0] REG_FLAP_FULL = 3'd5;
  localparam logic [2:0] REG_FLAP_ONE  = 3'd6;
  localparam logic [2:0] REG_FLAP_UP   = 3'd7;

  localparam logic [15:0] RST_NEUTRAL   = 16'd1500;
  localparam logic [7:0]  RST_TRIM      = 8'd128;
  localparam logic [7:0]  RST_GAIN      = 8'd4;
  localparam logic [15:0] RST_LOW_LIM   = 16'd1000;
  localparam logic [15:0] RST_HIGH_LIM  = 16'd2000;
  localparam logic [15:0] RST_FLAP_FULL = 16'd2000;
  localparam logic [15:0] RST_FLAP_ONE  = 16'd1750;
  localparam logic [15:0] RST_FLAP_UP   = 16'd1500;

  typedef enum logic [1:0] {
    FLAP_UP,
    FLAP_ONE,
    FLAP_FULL
  } flap_e;

  typedef struct packed {
    logic [15:0] neutral;
    logic [7:0]  trim;
    logic [7:0]  gain;
    logic [15:0] low_lim;
    logic [15:0] high_lim;
    logic [15:0] flap_down;
    logic [15:0] flap_one;
    logic [15:0] flap_up;
  } cfg_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic [7:0]         throttle;
    logic [7:0]         roll;
    logic [7:0]         pitch;
    logic [7:0]         yaw;
    flap_e              flap;
    logic               hold;
    logic               entry;
    logic signed [15:0] alt_filt;
    logic signed [31:0] bank;
  } mid_t;

  typedef struct packed {
    logic [15:0]        motor;
    logic [15:0]        aileron;
    logic [15:0]        elevator;
    logic [15:0]        rudder;
    logic [15:0]        flap;
    logic               hold;
    logic signed [15:0] alt_filt;
    logic signed [15:0] alt_err;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

/* sv/smh_fifo.sv */
// ----------------------------------------------------------------------------
// smh_fifo
// Small flop-based queue, registered storage, one push (when not full) and one pop (when not empty) a cycle.
// ----------------------------------------------------------------------------
module smh_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* sv/smh_front.sv */
// ----------------------------------------------------------------------------
// smh_front
// Sensor filters, bank integration, mode select and flap decode per tick.
// ----------------------------------------------------------------------------
module smh_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         throttle_channel_i,
  input  logic [7:0]         roll_channel_i,
  input  logic [7:0]         pitch_channel_i,
  input  logic [7:0]         yaw_channel_i,
  input  logic [7:0]         mode_knob_i,
  input  logic [7:0]         flap_switch_i,
  input  logic signed [15:0] altitude_sample_i,
  input  logic signed [7:0]  roll_rate_sample_i,
  output smh_pkg::mid_t      item_o
);
  import smh_pkg::*;

  logic signed [15:0] alt_f_q, alt_f_d;
  logic signed [7:0]  rr_f_q, rr_f_d;
  logic signed [7:0]  rr_prior_q;
  logic signed [31:0] bank_q, bank_d;
  logic               mode_q, mode_d;

  logic signed [24:0] alt_acc, alt_adj;
  logic signed [16:0] rr_acc, rr_adj;
  logic signed [8:0]  rr_diff, rr_dadj, rr_half, trap;
  logic signed [20:0] rate_prod;
  logic signed [33:0] bank_sum;
  flap_e              flap;

  always_comb begin
    // Q8 filters, truncated toward zero
    alt_acc = 25'(altitude_sample_i) * 25'sd179 + 25'(alt_f_q) * 25'sd77;
    alt_adj = alt_acc + (alt_acc[24] ? 25'sd255 : 25'sd0);
    alt_f_d = alt_adj[23:8];
    rr_acc  = 17'(roll_rate_sample_i) * 17'sd77 + 17'(rr_f_q) * 17'sd179;
    rr_adj  = rr_acc + (rr_acc[16] ? 17'sd255 : 17'sd0);
    rr_f_d  = rr_adj[15:8];

    // trapezoid step, 1311 = 0.02 in Q16.16
    rr_diff   = 9'(rr_f_d) - 9'(rr_prior_q);
    rr_dadj   = rr_diff + {8'd0, rr_diff[8]};
    rr_half   = rr_dadj >>> 1;
    trap      = 9'(rr_prior_q) + rr_half;
    rate_prod = 21'(trap) * 21'sd1311;
    bank_sum  = 34'(bank_q) + 34'(rate_prod);
    bank_d    = sat32(bank_sum);

    mode_d = mode_q;
    if (mode_knob_i > 8'd120 && mode_knob_i < 8'd135) begin
      mode_d = 1'b0;
    end else if ((mode_knob_i > 8'd135 && mode_knob_i < 8'd150) ||
                 (mode_knob_i > 8'd150 && mode_knob_i < 8'd160)) begin
      mode_d = 1'b1;
    end

    if (flap_switch_i > 8'd144) begin
      flap = FLAP_FULL;
    end else if (flap_switch_i > 8'd139 && flap_switch_i < 8'd144) begin
      flap = FLAP_ONE;
    end else begin
      flap = FLAP_UP;
    end

    item_o.throttle = throttle_channel_i;
    item_o.roll     = roll_channel_i;
    item_o.pitch    = pitch_channel_i;
    item_o.yaw      = yaw_channel_i;
    item_o.flap     = flap;
    item_o.hold     = mode_d;
    item_o.entry    = (mode_d != mode_q);
    item_o.alt_filt = alt_f_d;
    item_o.bank     = bank_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_f_q    <= '0;
      rr_f_q     <= '0;
      rr_prior_q <= '0;
      bank_q     <= '0;
      mode_q     <= 1'b0;
    end else if (accept_i) begin
      alt_f_q    <= alt_f_d;
      rr_f_q     <= rr_f_d;
      rr_prior_q <= rr_f_d;
      bank_q     <= bank_d;
      mode_q     <= mode_d;
    end
  end

endmodule

/* sv/smh_back.sv */
// ----------------------------------------------------------------------------
// smh_back
// Channel mapping and hold-mode PID laws, two stages into the result queue.
// ----------------------------------------------------------------------------
module smh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  smh_pkg::cfg_t cfg_i,
  input  logic          mid_valid_i,
  input  smh_pkg::mid_t mid_item_i,
  output logic          mid_pop_o,
  input  logic          out_full_i,
  output logic          out_push_o,
  output smh_pkg::out_t out_item_o
);
  import smh_pkg::*;

  typedef struct packed {
    logic               hold;
    logic               entry;
    logic [15:0]        motor;
    logic [15:0]        rudder;
    logic [15:0]        ail_dir;
    logic [15:0]        elev_dir;
    logic [15:0]        flap;
    logic signed [15:0] alt_filt;
    logic signed [15:0] alt_err_out;
    logic signed [15:0] err;
    logic signed [15:0] err_sum;
    logic signed [15:0] err_prior;
    logic signed [31:0] be;
    logic signed [31:0] bsum;
    logic signed [31:0] bprior;
  } stage_t;

  function automatic logic [15:0] map_ch(input logic [7:0] ch, input cfg_t c);
    logic signed [8:0]  dif;
    logic signed [17:0] prod;
    dif  = $signed({1'b0, ch}) - $signed({1'b0, c.trim});
    prod = 18'(dif) * $signed({10'd0, c.gain});
    return c.neutral + prod[15:0];
  endfunction

  // stage A state
  logic signed [15:0] tgt_alt_q, err_sum_q, err_prior_q;
  logic signed [31:0] tgt_bank_q, bsum_q, bprior_q;
  // stage B state
  logic [15:0]        elev_trim_q, ail_trim_q, last_elev_q, last_ail_q;

  stage_t             a_q, a_d;
  logic               a_v_q;
  logic               latch, a_load, b_fire;
  logic signed [15:0] tgt_alt_eff, err, err_sum;
  logic signed [31:0] tgt_bank_eff, be, bsum;

  logic [15:0]        elev_trim, ail_trim, elev, ail;
  logic signed [28:0] e_pd, e_x, e_xadj, e_q, e_hi, e_lo;
  logic signed [45:0] a_pd, a_x, a_xadj, a_qt, a_hi, a_lo;

  assign b_fire    = a_v_q && !out_full_i;
  assign a_load    = mid_valid_i && (!a_v_q || b_fire);
  assign mid_pop_o = a_load;
  assign out_push_o = b_fire;

  // stage A: errors, integrals, direct mapping
  always_comb begin
    latch        = mid_item_i.hold && mid_item_i.entry;
    tgt_alt_eff  = latch ? mid_item_i.alt_filt : tgt_alt_q;
    err          = mid_item_i.alt_filt - tgt_alt_eff;
    err_sum      = err_sum_q + err;
    tgt_bank_eff = latch ? mid_item_i.bank : tgt_bank_q;
    be           = sat32(34'(mid_item_i.bank) - 34'(tgt_bank_eff));
    bsum         = sat32(34'(bsum_q) + 34'(be));

    a_d.hold     = mid_item_i.hold;
    a_d.entry    = mid_item_i.entry;
    a_d.motor    = map_ch(mid_item_i.throttle, cfg_i);
    a_d.ail_dir  = map_ch(mid_item_i.roll, cfg_i);
    a_d.elev_dir = map_ch(mid_item_i.pitch, cfg_i);
    a_d.rudder   = map_ch(mid_item_i.yaw, cfg_i);
    case (mid_item_i.flap)
      FLAP_FULL: a_d.flap = cfg_i.flap_down;
      FLAP_ONE:  a_d.flap = cfg_i.flap_one;
      FLAP_UP:   a_d.flap = cfg_i.flap_up;
      default:   a_d.flap = cfg_i.flap_up;
    endcase
    a_d.alt_filt    = mid_item_i.alt_filt;
    a_d.alt_err_out = mid_item_i.hold ? err : err_prior_q;
    a_d.err         = err;
    a_d.err_sum     = err_sum;
    a_d.err_prior   = err_prior_q;
    a_d.be          = be;
    a_d.bsum        = bsum;
    a_d.bprior      = bprior_q;
  end

  // stage B: PID sums, truncating divide and clamp in hold mode; direct mapping otherwise
  always_comb begin
    elev_trim = (a_q.hold && a_q.entry) ? last_elev_q : elev_trim_q;
    ail_trim  = (a_q.hold && a_q.entry) ? last_ail_q : ail_trim_q;

    e_pd   = 29'(a_q.err_prior) - 29'(a_q.err);
    e_x    = $signed({11'd0, elev_trim, 2'b00}) -
             (29'(a_q.err) * 29'sd20 + 29'(a_q.err_sum) + e_pd * 29'sd400);
    e_xadj = e_x + (e_x[28] ? 29'sd3 : 29'sd0);
    e_q    = e_xadj >>> 2;
    e_hi   = $signed({13'd0, cfg_i.high_lim});
    e_lo   = $signed({13'd0, cfg_i.low_lim});

    a_pd   = 46'(a_q.bprior) - 46'(a_q.be);
    a_x    = $signed({12'd0, ail_trim, 18'd0}) -
             (46'(a_q.be) * 46'sd20 + 46'(a_q.bsum) + a_pd * 46'sd400);
    a_xadj = a_x + (a_x[45] ? 46'sd262143 : 46'sd0);
    a_qt   = a_xadj >>> 18;
    a_hi   = $signed({30'd0, cfg_i.high_lim});
    a_lo   = $signed({30'd0, cfg_i.low_lim});

    if (!a_q.hold) begin
      elev = a_q.elev_dir;
    end else if (e_q > e_hi) begin
      elev = cfg_i.high_lim;
    end else if (e_q < e_lo) begin
      elev = cfg_i.low_lim;
    end else begin
      elev = e_q[15:0];
    end

    if (!a_q.hold) begin
      ail = a_q.ail_dir;
    end else if (a_qt > a_hi) begin
      ail = cfg_i.high_lim;
    end else if (a_qt < a_lo) begin
      ail = cfg_i.low_lim;
    end else begin
      ail = a_qt[15:0];
    end

    out_item_o.motor    = a_q.motor;
    out_item_o.aileron  = ail;
    out_item_o.elevator = elev;
    out_item_o.rudder   = a_q.rudder;
    out_item_o.flap     = a_q.flap;
    out_item_o.hold     = a_q.hold;
    out_item_o.alt_filt = a_q.alt_filt;
    out_item_o.alt_err  = a_q.alt_err_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      tgt_alt_q   <= '0;
      err_sum_q   <= '0;
      err_prior_q <= '0;
      tgt_bank_q  <= '0;
      bsum_q      <= '0;
      bprior_q    <= '0;
      elev_trim_q <= '0;
      ail_trim_q  <= '0;
      last_elev_q <= '0;
      last_ail_q  <= '0;
    end else begin
      if (a_load) begin
        a_v_q <= 1'b1;
      end else if (b_fire) begin
        a_v_q <= 1'b0;
      end
      if (a_load && mid_item_i.hold) begin
        tgt_alt_q   <= tgt_alt_eff;
        err_sum_q   <= err_sum;
        err_prior_q <= err;
        tgt_bank_q  <= tgt_bank_eff;
        bsum_q      <= bsum;
        bprior_q    <= be;
      end
      if (b_fire) begin
        last_elev_q <= elev;
        last_ail_q  <= ail;
        if (a_q.hold && a_q.entry) begin
          elev_trim_q <= last_elev_q;
          ail_trim_q  <= last_ail_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_q <= a_d;
    end
  end

endmodule

/* sv/servo_mixer_with_hold_pid.sv */
// ----------------------------------------------------------------------------
// servo_mixer_with_hold_pid
// Servo mixer with altitude and bank hold; one result item per tick item.
//
//   channel   handshake              payload
//   input     push / full            six channels, altitude and roll samples
//   result    empty / pop            five servo commands, mode, altitude info
//   config    psel/penable/pwrite    paddr[4:2] selects register, 32-bit data
//
// One item per cycle sustained while the result queue does not fill. The
// result passes the middle queue, then the PID stage A register, into the
// result queue (front and stage B are combinational).
// Reset clears all filter, integral and target state and both queues.
// A full result queue stalls the back stages; the middle queue then fills
// and full rises, without losing or repeating any item.
// ----------------------------------------------------------------------------
module servo_mixer_with_hold_pid #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                throttle_channel_i,
  input  logic [7:0]                roll_channel_i,
  input  logic [7:0]                pitch_channel_i,
  input  logic [7:0]                yaw_channel_i,
  input  logic [7:0]                mode_knob_i,
  input  logic [7:0]                flap_switch_i,
  input  logic signed [15:0]        altitude_sample_i,
  input  logic signed [7:0]         roll_rate_sample_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [15:0]               motor_command_o,
  output logic [15:0]               aileron_command_o,
  output logic [15:0]               elevator_command_o,
  output logic [15:0]               rudder_command_o,
  output logic [15:0]               flap_command_o,
  output logic                      hold_active_o,
  output logic signed [15:0]        filtered_altitude_o,
  output logic signed [15:0]        altitude_error_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [smh_pkg::AddrW-1:0] paddr,
  input  logic [smh_pkg::DataW-1:0] pwdata,
  output logic [smh_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import smh_pkg::*;

  cfg_t cfg_q;
  mid_t front_item, mid_head;
  out_t back_item, out_head;
  logic accept, mid_empty, mid_full, mid_pop, out_push, out_full;
  logic cfg_wr;

  assign full   = mid_full;
  assign accept = push && !mid_full;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neutral   <= RST_NEUTRAL;
      cfg_q.trim      <= RST_TRIM;
      cfg_q.gain      <= RST_GAIN;
      cfg_q.low_lim   <= RST_LOW_LIM;
      cfg_q.high_lim  <= RST_HIGH_LIM;
      cfg_q.flap_down <= RST_FLAP_FULL;
      cfg_q.flap_one  <= RST_FLAP_ONE;
      cfg_q.flap_up   <= RST_FLAP_UP;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_NEUTRAL:   cfg_q.neutral   <= pwdata[15:0];
        REG_TRIM:      cfg_q.trim      <= pwdata[7:0];
        REG_GAIN:      cfg_q.gain      <= pwdata[7:0];
        REG_LOW_LIM:   cfg_q.low_lim   <= pwdata[15:0];
        REG_HIGH_LIM:  cfg_q.high_lim  <= pwdata[15:0];
        REG_FLAP_FULL: cfg_q.flap_down <= pwdata[15:0];
        REG_FLAP_ONE:  cfg_q.flap_one  <= pwdata[15:0];
        REG_FLAP_UP:   cfg_q.flap_up   <= pwdata[15:0];
        default:       cfg_q.flap_up   <= cfg_q.flap_up;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_NEUTRAL:   prdata = {16'd0, cfg_q.neutral};
      REG_TRIM:      prdata = {24'd0, cfg_q.trim};
      REG_GAIN:      prdata = {24'd0, cfg_q.gain};
      REG_LOW_LIM:   prdata = {16'd0, cfg_q.low_lim};
      REG_HIGH_LIM:  prdata = {16'd0, cfg_q.high_lim};
      REG_FLAP_FULL: prdata = {16'd0, cfg_q.flap_down};
      REG_FLAP_ONE:  prdata = {16'd0, cfg_q.flap_one};
      REG_FLAP_UP:   prdata = {16'd0, cfg_q.flap_up};
      default:       prdata = '0;
    endcase
  end

  smh_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .throttle_channel_i (throttle_channel_i),
    .roll_channel_i     (roll_channel_i),
    .pitch_channel_i    (pitch_channel_i),
    .yaw_channel_i      (yaw_channel_i),
    .mode_knob_i        (mode_knob_i),
    .flap_switch_i      (flap_switch_i),
    .altitude_sample_i  (altitude_sample_i),
    .roll_rate_sample_i (roll_rate_sample_i),
    .item_o             (front_item)
  );

  smh_fifo #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_item),
    .pop_i   (mid_pop),
    .data_o  (mid_head),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  smh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_valid_i (!mid_empty),
    .mid_item_i  (mid_head),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_item_o  (back_item)
  );

  smh_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_item),
    .pop_i   (pop),
    .data_o  (out_head),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign motor_command_o     = out_head.motor;
  assign aileron_command_o   = out_head.aileron;
  assign elevator_command_o  = out_head.elevator;
  assign rudder_command_o    = out_head.rudder;
  assign flap_command_o      = out_head.flap;
  assign hold_active_o       = out_head.hold;
  assign filtered_altitude_o = out_head.alt_filt;
  assign altitude_error_o    = out_head.alt_err;

endmodule

/* sv/smh_checker.sv */
// ----------------------------------------------------------------------------
// smh_checker
// Port-level checks on the servo mixer, bound to the top level.
// ----------------------------------------------------------------------------
module smh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] motor_command_o,
  input logic [15:0] aileron_command_o,
  input logic        pready
);

  // queues are cleared while reset is held
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty in reset");

  a_rst_not_full: assert property (@(posedge clk_i) !rst_ni |-> !full)
    else $error("input side full in reset");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready dropped");

  // a waiting item stays put until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(motor_command_o) &&
                          $stable(aileron_command_o)))
    else $error("waiting item changed before pop");

endmodule

bind servo_mixer_with_hold_pid smh_checker u_smh_checker (.*);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the servo mixer with hold PID. It runs a directed stimulus
// table and then random ticks through the push/full input and the
// empty/pop output, with configuration phases over the APB port. Every
// result item is checked field by field against a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import smh_pkg::*;

  localparam int unsigned NRAND = 1725;

  typedef struct packed {
    logic [7:0]         thr;
    logic [7:0]         rol;
    logic [7:0]         pit;
    logic [7:0]         yaw;
    logic [7:0]         knob;
    logic [7:0]         flap;
    logic signed [15:0] alt;
    logic signed [7:0]  rate;
  } tick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic push = 1'b0;
  logic full;
  tick_t tk = '0;
  logic empty;
  logic pop = 1'b0;
  logic [15:0] motor_o, ail_o, elev_o, rud_o, flap_o;
  logic hold_o;
  logic signed [15:0] falt_o, aerr_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  always #2 clk_i = ~clk_i;

  servo_mixer_with_hold_pid uut (
    .clk_i, .rst_ni, .push, .full,
    .throttle_channel_i(tk.thr), .roll_channel_i(tk.rol), .pitch_channel_i(tk.pit),
    .yaw_channel_i(tk.yaw), .mode_knob_i(tk.knob), .flap_switch_i(tk.flap),
    .altitude_sample_i(tk.alt), .roll_rate_sample_i(tk.rate),
    .empty, .pop,
    .motor_command_o(motor_o), .aileron_command_o(ail_o), .elevator_command_o(elev_o),
    .rudder_command_o(rud_o), .flap_command_o(flap_o), .hold_active_o(hold_o),
    .filtered_altitude_o(falt_o), .altitude_error_o(aerr_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state
  cfg_t cfg;
  logic mode_q, prev_mode_q;
  longint alt_f, rate_f, rate_prior, bank, tgt_bank, tgt_alt;
  longint elev_trim, ail_trim, aerr_sum, aerr_prior, berr_sum, berr_prior;
  longint last_elev, last_ail;

  out_t servo_expect_q[$];
  int errors = 0;
  int checked = 0;
  int holds_seen = 0;
  int send_idle = 16, recv_idle = 83;
  bit recv_hold = 1'b0;

  function automatic longint sat_i32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap16(longint v);
    logic signed [15:0] w;
    w = v[15:0];
    return longint'(w);
  endfunction

  function automatic logic [15:0] map_ch(logic [7:0] ch);
    longint v;
    v = longint'(cfg.neutral) + (longint'(ch) - longint'(cfg.trim)) * longint'(cfg.gain);
    return v[15:0];
  endfunction

  function automatic logic [15:0] clamp_lim(longint v);
    if (v > longint'(cfg.high_lim)) return cfg.high_lim;
    if (v < longint'(cfg.low_lim)) return cfg.low_lim;
    return v[15:0];
  endfunction

  task automatic predict_servo(input tick_t t);
    out_t o;
    longint trap, e, x, be, aout;
    logic entry;
    alt_f = (179 * longint'(t.alt) + 77 * alt_f) / 256;
    rate_f = (77 * longint'(t.rate) + 179 * rate_f) / 256;
    trap = rate_prior + (rate_f - rate_prior) / 2;
    bank = sat_i32(bank + trap * 1311);
    rate_prior = rate_f;
    if (t.knob > 120 && t.knob < 135) mode_q = 1'b0;
    else if ((t.knob > 135 && t.knob < 150) || (t.knob > 150 && t.knob < 160))
      mode_q = 1'b1;
    entry = mode_q != prev_mode_q;
    o.motor = map_ch(t.thr);
    o.rudder = map_ch(t.yaw);
    if (t.flap > 144) o.flap = cfg.flap_down;
    else if (t.flap > 139 && t.flap < 144) o.flap = cfg.flap_one;
    else o.flap = cfg.flap_up;
    if (!mode_q) begin
      o.aileron = map_ch(t.rol);
      o.elevator = map_ch(t.pit);
      aout = aerr_prior;
    end else begin
      if (entry) begin
        tgt_alt = alt_f;
        tgt_bank = bank;
        elev_trim = last_elev;
        ail_trim = last_ail;
      end
      e = wrap16(alt_f - tgt_alt);
      aerr_sum = wrap16(aerr_sum + e);
      x = 4 * elev_trim - (20 * e + aerr_sum + 400 * (aerr_prior - e));
      o.elevator = clamp_lim(x / 4);
      aerr_prior = e;
      aout = e;
      be = sat_i32(bank - tgt_bank);
      berr_sum = sat_i32(berr_sum + be);
      x = 4 * ail_trim * 65536 - (20 * be + berr_sum + 400 * (berr_prior - be));
      o.aileron = clamp_lim(x / 262144);
      berr_prior = be;
    end
    last_elev = o.elevator;
    last_ail = o.aileron;
    prev_mode_q = mode_q;
    o.hold = mode_q;
    o.alt_filt = alt_f[15:0];
    o.alt_err = aout[15:0];
    servo_expect_q.push_back(o);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s at %0t: got %0d want %0d", what, $realtime, got, want);
    errors++;
  endtask

  // result side
  always @(posedge clk_i) begin
    out_t w;
    if (rst_ni && pop && !empty) begin
      checked++;
      if (hold_o) holds_seen++;
      if (servo_expect_q.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        w = servo_expect_q.pop_front();
        if (motor_o !== w.motor) report_mismatch("motor", motor_o, w.motor);
        if (ail_o !== w.aileron) report_mismatch("aileron", ail_o, w.aileron);
        if (elev_o !== w.elevator) report_mismatch("elevator", elev_o, w.elevator);
        if (rud_o !== w.rudder) report_mismatch("rudder", rud_o, w.rudder);
        if (flap_o !== w.flap) report_mismatch("flap", flap_o, w.flap);
        if (hold_o !== w.hold) report_mismatch("hold", hold_o, w.hold);
        if (falt_o !== w.alt_filt) report_mismatch("filt_alt", falt_o, w.alt_filt);
        if (aerr_o !== w.alt_err) report_mismatch("alt_err", aerr_o, w.alt_err);
      end
    end
    if (recv_hold) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_tick(input tick_t t);
    push <= 1'b1;
    tk <= t;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_servo(t);
    if (send_idle > 0) begin
      if ($urandom_range(99) < send_idle) begin
        push <= 1'b0;
        @(posedge clk_i);
        while ($urandom_range(99) < send_idle) @(posedge clk_i);
      end
    end
  endtask

  task automatic end_push();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (servo_expect_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00}); pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_NEUTRAL:   cfg.neutral = v[15:0];
      REG_TRIM:      cfg.trim = v[7:0];
      REG_GAIN:      cfg.gain = v[7:0];
      REG_LOW_LIM:   cfg.low_lim = v[15:0];
      REG_HIGH_LIM:  cfg.high_lim = v[15:0];
      REG_FLAP_FULL: cfg.flap_down = v[15:0];
      REG_FLAP_ONE:  cfg.flap_one = v[15:0];
      default:       cfg.flap_up = v[15:0];
    endcase
  endtask

  task automatic write_cfg(input cfg_t c);
    apb_write(REG_NEUTRAL, 32'(c.neutral));
    apb_write(REG_TRIM, 32'(c.trim));
    apb_write(REG_GAIN, 32'(c.gain));
    apb_write(REG_LOW_LIM, 32'(c.low_lim));
    apb_write(REG_HIGH_LIM, 32'(c.high_lim));
    apb_write(REG_FLAP_FULL, 32'(c.flap_down));
    apb_write(REG_FLAP_ONE, 32'(c.flap_one));
    apb_write(REG_FLAP_UP, 32'(c.flap_up));
  endtask

  function automatic tick_t rand_tick(bit hold_bias);
    tick_t t;
    t = tick_t'(72'({$urandom, $urandom, $urandom}));
    case ($urandom_range(9))
      0, 1, 2: t.knob = 8'($urandom_range(134, 121));
      3, 4, 5: t.knob = hold_bias ? 8'($urandom_range(159, 136)) : 8'($urandom_range(134, 121));
      6:       t.knob = 8'($urandom_range(159, 151));
      default: ;
    endcase
    if ($urandom_range(3) == 0) t.flap = 8'($urandom_range(146, 138));
    if ($urandom_range(3) != 0) t.alt = 16'($signed(12'($urandom)));
    return t;
  endfunction

  typedef struct packed {
    tick_t t;
    logic chk;
    out_t o;
  } row_t;

  row_t dir_tbl[$];

  task automatic add_row(input tick_t t);
    row_t r;
    r.t = t; r.chk = 1'b0; r.o = '0;
    dir_tbl.push_back(r);
  endtask

  initial begin
    #3000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    cfg_t c;
    row_t r;
    out_t got;
    rst_ni = 1'b0;
    cfg = '{RST_NEUTRAL, RST_TRIM, RST_GAIN, RST_LOW_LIM, RST_HIGH_LIM,
            RST_FLAP_FULL, RST_FLAP_ONE, RST_FLAP_UP};
    mode_q = 0; prev_mode_q = 0;
    alt_f = 0; rate_f = 0; rate_prior = 0; bank = 0; tgt_bank = 0; tgt_alt = 0;
    elev_trim = 0; ail_trim = 0; aerr_sum = 0; aerr_prior = 0;
    berr_sum = 0; berr_prior = 0; last_elev = 0; last_ail = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first row after reset is typed in, centred sticks give neutral
    r.t = '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 16'sd0, 8'sd0};
    r.chk = 1'b1;
    r.o = '{16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd1500, 1'b0, 16'sd0, 16'sd0};
    dir_tbl.push_back(r);
    add_row('{8'd255, 8'd0, 8'd255, 8'd0, 8'd120, 8'd145, 16'sh7fff, 8'sd127});
    add_row('{8'd0, 8'd255, 8'd0, 8'd255, 8'd121, 8'd144, -16'sh8000, -8'sd128});
    add_row('{8'd10, 8'd20, 8'd30, 8'd40, 8'd135, 8'd143, 16'sd100, 8'sd5});
    add_row('{8'd10, 8'd20, 8'd30, 8'd40, 8'd136, 8'd140, 16'sd300, 8'sd50});
    add_row('{8'd10, 8'd20, 8'd30, 8'd40, 8'd149, 8'd139, 16'sh7fff, 8'sd127});
    add_row('{8'd10, 8'd20, 8'd30, 8'd40, 8'd150, 8'd255, -16'sh8000, -8'sd128});
    add_row('{8'd10, 8'd20, 8'd30, 8'd40, 8'd160, 8'd0, 16'sh7fff, 8'sd127});
    add_row('{8'd10, 8'd20, 8'd30, 8'd40, 8'd134, 8'd141, 16'sd0, 8'sd0});
    add_row('{8'd10, 8'd20, 8'd30, 8'd40, 8'd151, 8'd142, 16'sd0, -8'sd1});
    add_row('{8'd10, 8'd20, 8'd30, 8'd40, 8'd159, 8'd146, -16'sd1, 8'sd1});
    add_row('{8'd10, 8'd20, 8'd30, 8'd40, 8'd255, 8'd0, 16'sd5, 8'sd0});
    add_row('{8'd10, 8'd20, 8'd30, 8'd40, 8'd0, 8'd0, 16'sd5, 8'sd0});
    add_row('{8'd128, 8'd128, 8'd128, 8'd128, 8'd125, 8'd0, 16'sd0, 8'sd0});
    foreach (dir_tbl[i]) begin
      r = dir_tbl[i];
      send_tick(r.t);
      // the prediction for this row is the newest queue entry
      if (r.chk) begin
        got = servo_expect_q[$];
        if (got !== r.o) report_mismatch("typed row", i, 0);
      end
    end
    end_push();
    drain();

    // random phases: several settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: c = '{16'd1500, 8'd128, 8'd4, 16'd1000, 16'd2000, 16'd2000, 16'd1750, 16'd1500};
        1: c = '{16'hffff, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
        2: c = '{16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        3: c = '{16'd1500, 8'd128, 8'd4, 16'd2000, 16'd1000, 16'd1, 16'd2, 16'd3};
        default: c = cfg_t'(112'({$urandom, $urandom, $urandom, $urandom}));
      endcase
      if (ph == 4) c.low_lim = 16'd0;
      write_cfg(c);
      if (ph == 3) begin
        send_idle = 83; recv_idle = 16;
      end else if (ph == 5) begin
        send_idle = 0; recv_idle = 0;
      end
      for (int k = 0; k < NRAND / 7; k++) begin
        if (ph == 1 && k == 30) begin
          recv_hold = 1'b1;
          fork
            begin
              repeat (60) @(posedge clk_i);
              recv_hold = 1'b0;
            end
          join_none
        end
        if (ph == 2 && k == 40) begin
          end_push();
          drain();
        end
        send_tick(rand_tick(1'b1));
      end
      end_push();
      drain();
    end
    repeat (10) @(posedge clk_i);
    $display("covered %0d result items, %0d in hold mode, over 7 register settings",
             checked, holds_seen);
    $display("with input and output stalls, a long output hold-off and a full drain");
    if (errors == 0 && servo_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* files.f */
sv/smh_pkg.sv
sv/smh_fifo.sv
sv/smh_front.sv
sv/smh_back.sv
sv/servo_mixer_with_hold_pid.sv
sv/smh_checker.sv
dv/tb_top.sv
